// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl that checks itself
// expects clk and arst_n in scope at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/i2cm_pkg.sv =====
// types and constants for the i2c master byte engine
// no dependencies
`default_nettype none

package i2cm_pkg;

	typedef enum logic [2:0] {
		CMD_START     = 3'd0,
		CMD_STOP      = 3'd1,
		CMD_WRITE     = 3'd2,
		CMD_READ_ACK  = 3'd3,
		CMD_READ_NACK = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_READY     = 2'd0,
		ST_BUS_BUSY  = 2'd1,
		ST_BUS_ERROR = 2'd2
	} status_t;

	// idle, then one code per phase of a primitive
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_STEP0 = 3'd1,
		PH_STEP1 = 3'd2,
		PH_STEP2 = 3'd3,
		PH_STEP3 = 3'd4,
		PH_STEP4 = 3'd5
	} phase_t;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic       kind;
		logic [2:0] command;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] bit_index;
		logic [7:0] shift_byte;
		logic [9:0] tick_count;
		cmd_t       active_cmd;
		logic       scl;
		logic       sda;
		status_t    last_status;
		logic [7:0] read_byte;
		logic       nack;
	} engine_state_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       nack_seen;
		status_t    status;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/i2cm_step.sv =====
// next-state and result logic for one tick of the i2c master byte engine
// depends on i2cm_pkg
`default_nettype none

module i2cm_step
	import i2cm_pkg::*;
(
	input  engine_state_t cur_state,
	input  tick_t         tick,
	input  logic [9:0]    half_period,
	output engine_state_t nxt_state,
	output result_t       res
);

	engine_state_t s;
	logic          fin;
	logic          shown_scl;
	logic          shown_sda;
	logic [9:0]    hold;

	// line drive on entry to a phase
	function automatic engine_state_t enter_step(engine_state_t st, phase_t ph);
		engine_state_t r;
		r = st;
		r.phase = ph;
		r.tick_count = '0;
		case (r.active_cmd)
			CMD_START: begin
				if (ph == PH_STEP0) r.sda = 1'b1;
				else if (ph == PH_STEP1) r.scl = 1'b1;
				else if (ph == PH_STEP2) r.sda = 1'b0;
				else r.scl = 1'b0;
			end
			CMD_STOP: begin
				if (ph == PH_STEP0) r.sda = 1'b0;
				else if (ph == PH_STEP1) r.scl = 1'b1;
				else r.sda = 1'b1;
			end
			CMD_WRITE: begin
				if (ph == PH_STEP0) begin
					r.scl = 1'b0;
					r.sda = r.shift_byte[7];
				end else if (ph == PH_STEP1) begin
					r.scl = 1'b1;
				end else if (ph == PH_STEP2) begin
					r.scl = 1'b0;
					r.sda = 1'b1;
				end else begin
					r.scl = 1'b1;
				end
			end
			default: begin
				if (ph == PH_STEP0) r.scl = 1'b1;
				else if (ph == PH_STEP1) r.scl = 1'b0;
				else if (ph == PH_STEP2) r.sda = (r.active_cmd != CMD_READ_ACK);
				else if (ph == PH_STEP3) r.scl = 1'b1;
				else r.scl = 1'b0;
			end
		endcase
		return r;
	endfunction

	assign hold = (half_period == '0) ? 10'd1 : half_period;

	always_comb begin : next_state
		s = cur_state;
		fin = 1'b0;
		if (s.phase == PH_IDLE && tick.kind && tick.command <= CMD_READ_NACK) begin
			s.active_cmd = cmd_t'(tick.command);
			s.bit_index = '0;
			if (tick.command == CMD_WRITE) begin
				s.shift_byte = tick.write_data;
				s.scl = 1'b0;
			end else if (tick.command >= CMD_READ_ACK) begin
				s.shift_byte = '0;
				s.sda = 1'b1;
				s.scl = 1'b0;
			end
			s = enter_step(s, PH_STEP0);
		end
		shown_scl = s.scl;
		shown_sda = s.sda;
		if (s.phase != PH_IDLE) begin
			s.tick_count = s.tick_count + 10'd1;
			if (s.tick_count >= hold) begin
				case (s.active_cmd)
					CMD_START: begin
						if (s.phase == PH_STEP1 && !tick.sda_in) begin
							s.last_status = ST_BUS_BUSY;
							fin = 1'b1;
						end else if (s.phase == PH_STEP3) begin
							s.last_status = tick.sda_in ? ST_BUS_ERROR : ST_READY;
							fin = 1'b1;
						end else begin
							s = enter_step(s, phase_t'(s.phase + 3'd1));
						end
					end
					CMD_STOP: begin
						if (s.phase == PH_STEP2) fin = 1'b1;
						else s = enter_step(s, phase_t'(s.phase + 3'd1));
					end
					CMD_WRITE: begin
						if (s.phase == PH_STEP1) begin
							s.shift_byte = {s.shift_byte[6:0], 1'b0};
							s.bit_index = s.bit_index + 4'd1;
							s = enter_step(s, (s.bit_index < BITS_PER_BYTE) ? PH_STEP0 : PH_STEP2);
						end else if (s.phase == PH_STEP3) begin
							s.nack = tick.sda_in;
							s.scl = 1'b0;
							s.sda = 1'b1;
							fin = 1'b1;
						end else begin
							s = enter_step(s, phase_t'(s.phase + 3'd1));
						end
					end
					default: begin
						if (s.phase == PH_STEP0) begin
							s.shift_byte = {s.shift_byte[6:0], tick.sda_in};
							s = enter_step(s, PH_STEP1);
						end else if (s.phase == PH_STEP1) begin
							s.bit_index = s.bit_index + 4'd1;
							s = enter_step(s, (s.bit_index < BITS_PER_BYTE) ? PH_STEP0 : PH_STEP2);
						end else if (s.phase == PH_STEP4) begin
							s.sda = 1'b1;
							s.read_byte = s.shift_byte;
							fin = 1'b1;
						end else begin
							s = enter_step(s, phase_t'(s.phase + 3'd1));
						end
					end
				endcase
				if (fin) begin
					s.phase = PH_IDLE;
					s.tick_count = '0;
				end
			end
		end
	end

	assign nxt_state = s;

	always_comb begin : result_out
		res.scl_out   = shown_scl;
		res.sda_out   = shown_sda;
		res.busy_res  = (s.phase != PH_IDLE);
		res.done_res  = fin;
		res.read_data = s.read_byte;
		res.nack_seen = s.nack;
		res.status    = s.last_status;
	end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_byte_engine.sv =====
// Tick-driven master for a two-wire open-drain bus. Every accepted input transaction is one
// bus tick and yields exactly one result transaction: the SCL/SDA drive in effect during that
// tick plus busy, done, the last read byte, the last write's ACK level and the start status.
// A tick with kind set starts a primitive (start, stop, write byte, read with ACK or NACK) if
// the engine is idle; commands while busy or with an unknown code are dropped. Each phase of a
// primitive holds for half_period_ticks ticks (zero acts as one), SDA is sampled on the last
// tick of a phase. Throughput is one tick per clock while no result waits under out_stall:
// the tick sits in an input register, and one pass of next-state logic updates the engine
// state and loads the result register as the tick moves on. The result register is the only
// thing that can hold off input; ticks stall only while a result waits under out_stall.
// Configure half_period_ticks through cfg_valid/cfg_data while no tick is in flight.
// depends on i2cm_pkg, i2cm_step and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module i2c_master_byte_engine
	import i2cm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,

	// configuration write channel
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [9:0] cfg_data,

	// tick input
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       kind,
	input  wire logic [2:0] command,
	input  wire logic [7:0] write_data,
	input  wire logic       sda_in,

	// result output
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            scl_out,
	output logic            sda_out,
	output logic            busy_res,
	output logic            done_res,
	output logic [7:0]      read_data,
	output logic            nack_seen,
	output logic [1:0]      status
);

	// half period register
	logic [9:0]    half_period_q;

	// input stage
	logic          valid_s1;
	tick_t         tick_s1;

	// engine state and result stage
	engine_state_t state_q;
	engine_state_t state_nxt;
	result_t       res_nxt;
	logic          valid_s2;
	result_t       res_s2;

	logic          advance;

	// the input stage moves on whenever the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= 10'd2;
		end else if (cfg_valid && cfg_ready) begin
			half_period_q <= cfg_data;
		end
	end

	// input register, payload without reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tick_s1.kind       <= kind;
			tick_s1.command    <= command;
			tick_s1.write_data <= write_data;
			tick_s1.sda_in     <= sda_in;
		end
	end

	// one tick of the engine
	i2cm_step u_step (
		.cur_state   (state_q),
		.tick        (tick_s1),
		.half_period (half_period_q),
		.nxt_state   (state_nxt),
		.res         (res_nxt)
	);

	// engine state; lines released on SDA, SCL pulled low after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_IDLE;
			state_q.bit_index   <= '0;
			state_q.shift_byte  <= '0;
			state_q.tick_count  <= '0;
			state_q.active_cmd  <= CMD_START;
			state_q.scl         <= 1'b0;
			state_q.sda         <= 1'b1;
			state_q.last_status <= ST_READY;
			state_q.read_byte   <= '0;
			state_q.nack        <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign scl_out   = res_s2.scl_out;
	assign sda_out   = res_s2.sda_out;
	assign busy_res  = res_s2.busy_res;
	assign done_res  = res_s2.done_res;
	assign read_data = res_s2.read_data;
	assign nack_seen = res_s2.nack_seen;
	assign status    = res_s2.status;

	// a completing primitive leaves the engine idle
	`ASSERT_IMPL(a_done_not_busy, valid_s2 && res_s2.done_res, !res_s2.busy_res)
	// input is held off only by a waiting result
	`ASSERT_IMPL(a_stall_cause, in_stall, valid_s2 && out_stall)
	// engine state moves only with a tick
	`ASSERT_NEXT(a_state_hold, !advance, $stable(state_q))
	// the phase counter is clear whenever idle
	`ASSERT_IMPL(a_idle_count, state_q.phase == PH_IDLE, state_q.tick_count == '0)

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking bench for the i2c master byte engine: directed ticks, then random bus traffic
// predicts every result transaction with its own model of the engine and checks it in order
// depends on i2cm_pkg and the i2c_master_byte_engine rtl
module tb_top
	import i2cm_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// command codes the engine must drop
	localparam logic [2:0] UNUSED_CMD_A = 3'd5;
	localparam logic [2:0] UNUSED_CMD_B = 3'd6;
	localparam logic [2:0] UNUSED_CMD_C = 3'd7;

	localparam logic [9:0] HALF_PERIOD_RESET = 10'd2;
	// half periods from here up get a single primitive per phase
	localparam logic [9:0] SLOW_HALF_PERIOD = 10'd64;
	localparam int PHASE_TICKS = 70;
	// random phase that runs with no idling on either side
	localparam int QUIET_PHASE = 1;
	localparam int IDLE_PERCENT = 23;
	localparam int RUN_LIMIT_NS = 400_000;

	localparam logic [9:0] HALF_PERIOD_PLAN [7] = '{
		10'd1, 10'd3, 10'd64, 10'd0, 10'd2, 10'd6, 10'd1
	};

	// how the sda samples are filled while a directed primitive runs
	typedef enum logic [1:0] {
		FILL_NONE,
		FILL_SLAVE,
		FILL_LOW,
		FILL_HIGH
	} fill_e;

	typedef struct packed {
		logic       kind;
		logic [2:0] command;
		logic [7:0] write_data;
		logic       sda_in;
		fill_e      fill;
		logic       typed;
		result_t    want;
	} plan_row_t;

	localparam result_t NO_CHECK = '0;
	// idle engine right after reset: scl pulled low, sda released
	localparam result_t AFTER_RESET = '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, ST_READY};
	// start aborted by sda low once scl is released, both lines left released
	localparam result_t BUS_BUSY_DONE = '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, ST_BUS_BUSY};
	// start finished with sda still high after both lines were pulled low
	localparam result_t BUS_ERROR_DONE = '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, ST_BUS_ERROR};

	// typed-in expectations apply to the last tick of a row, fill included
	localparam plan_row_t DIRECTED_PLAN [16] = '{
		'{1'b0, UNUSED_CMD_C,  8'hFF, 1'b1, FILL_NONE,  1'b1, AFTER_RESET},
		'{1'b1, UNUSED_CMD_A,  8'h00, 1'b0, FILL_NONE,  1'b1, AFTER_RESET},
		'{1'b1, UNUSED_CMD_C,  8'hFF, 1'b1, FILL_NONE,  1'b1, AFTER_RESET},
		'{1'b0, CMD_START,     8'h00, 1'b0, FILL_NONE,  1'b1, AFTER_RESET},
		'{1'b1, CMD_START,     8'h5A, 1'b1, FILL_LOW,   1'b1, BUS_BUSY_DONE},
		'{1'b1, CMD_START,     8'hA5, 1'b1, FILL_HIGH,  1'b1, BUS_ERROR_DONE},
		'{1'b1, CMD_START,     8'h00, 1'b1, FILL_SLAVE, 1'b0, NO_CHECK},
		'{1'b1, CMD_WRITE,     8'hFF, 1'b0, FILL_HIGH,  1'b0, NO_CHECK},
		'{1'b1, CMD_WRITE,     8'h00, 1'b1, FILL_NONE,  1'b0, NO_CHECK},
		'{1'b1, CMD_READ_ACK,  8'hFF, 1'b0, FILL_LOW,   1'b0, NO_CHECK},
		'{1'b1, CMD_READ_ACK,  8'h3C, 1'b1, FILL_HIGH,  1'b0, NO_CHECK},
		'{1'b1, CMD_READ_NACK, 8'hC3, 1'b0, FILL_LOW,   1'b0, NO_CHECK},
		'{1'b1, CMD_READ_NACK, 8'h00, 1'b1, FILL_SLAVE, 1'b0, NO_CHECK},
		'{1'b1, UNUSED_CMD_B,  8'h81, 1'b1, FILL_NONE,  1'b0, NO_CHECK},
		'{1'b1, CMD_STOP,      8'h7E, 1'b0, FILL_SLAVE, 1'b0, NO_CHECK},
		'{1'b1, CMD_STOP,      8'hFF, 1'b1, FILL_HIGH,  1'b0, NO_CHECK}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [9:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       kind = 1'b0;
	logic [2:0] command = '0;
	logic [7:0] write_data = '0;
	logic       sda_in = 1'b1;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       nack_seen;
	logic [1:0] status;

	// predicted engine state and its copy of the half period register
	logic [9:0] hp_cfg;
	phase_t     eng_phase;
	logic [3:0] eng_bits;
	logic [7:0] eng_shift;
	logic [9:0] eng_count;
	cmd_t       eng_cmd;
	logic       drv_scl;
	logic       drv_sda;
	status_t    eng_status;
	logic [7:0] eng_read;
	logic       eng_nack;

	result_t line_results [$];
	result_t got_result;
	result_t want_result;
	int      fail_count = 0;
	int      ticks_sent = 0;
	bit      gaps_on = 1'b0;

	i2c_master_byte_engine DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.command    (command),
		.write_data (write_data),
		.sda_in     (sda_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl_out    (scl_out),
		.sda_out    (sda_out),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_data  (read_data),
		.nack_seen  (nack_seen),
		.status     (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	initial begin
		#RUN_LIMIT_NS;
		$display("Test completed with failures");
		$finish;
	end

	function automatic void reset_bus_engine();
		hp_cfg = HALF_PERIOD_RESET;
		eng_phase = PH_IDLE;
		eng_bits = '0;
		eng_shift = '0;
		eng_count = '0;
		eng_cmd = CMD_START;
		drv_scl = 1'b0;
		drv_sda = 1'b1;
		eng_status = ST_READY;
		eng_read = '0;
		eng_nack = 1'b0;
	endfunction

	// set the line drive for step s of the active primitive and restart the tick count
	function automatic void enter_phase(input int s);
		eng_phase = phase_t'(3'(s + 1));
		eng_count = '0;
		case (eng_cmd)
		CMD_START: begin
			if (s == 0) drv_sda = 1'b1;
			else if (s == 1) drv_scl = 1'b1;
			else if (s == 2) drv_sda = 1'b0;
			else drv_scl = 1'b0;
		end
		CMD_STOP: begin
			if (s == 0) drv_sda = 1'b0;
			else if (s == 1) drv_scl = 1'b1;
			else drv_sda = 1'b1;
		end
		CMD_WRITE: begin
			if (s == 0) begin
				drv_scl = 1'b0;
				drv_sda = eng_shift[7];
			end else if (s == 1) begin
				drv_scl = 1'b1;
			end else if (s == 2) begin
				drv_scl = 1'b0;
				drv_sda = 1'b1;
			end else begin
				drv_scl = 1'b1;
			end
		end
		default: begin
			if (s == 0) drv_scl = 1'b1;
			else if (s == 1) drv_scl = 1'b0;
			else if (s == 2) drv_sda = (eng_cmd == CMD_READ_NACK);
			else if (s == 3) drv_scl = 1'b1;
			else drv_scl = 1'b0;
		end
		endcase
	endfunction

	// close step s with the sda sample of its last tick, returns the next step or -1
	function automatic int finish_phase(input int s, input logic sda);
		case (eng_cmd)
		CMD_START: begin
			if (s == 1 && !sda) begin
				eng_status = ST_BUS_BUSY;
				return -1;
			end
			if (s == 3) begin
				eng_status = sda ? ST_BUS_ERROR : ST_READY;
				return -1;
			end
		end
		CMD_STOP: begin
			if (s == 2) return -1;
		end
		CMD_WRITE: begin
			if (s == 1) begin
				eng_shift = {eng_shift[6:0], 1'b0};
				eng_bits = eng_bits + 4'd1;
				return (eng_bits < BITS_PER_BYTE) ? 0 : 2;
			end
			if (s == 3) begin
				eng_nack = sda;
				drv_scl = 1'b0;
				drv_sda = 1'b1;
				return -1;
			end
		end
		default: begin
			if (s == 0) begin
				eng_shift = {eng_shift[6:0], sda};
				return 1;
			end
			if (s == 1) begin
				eng_bits = eng_bits + 4'd1;
				return (eng_bits < BITS_PER_BYTE) ? 0 : 2;
			end
			if (s == 4) begin
				drv_sda = 1'b1;
				eng_read = eng_shift;
				return -1;
			end
		end
		endcase
		return s + 1;
	endfunction

	// one bus tick through the predicted engine, returns the result transaction it causes
	function automatic result_t advance_bus_engine(input tick_t t);
		logic [9:0] hold;
		logic       shown_scl;
		logic       shown_sda;
		logic       done;
		int         next;
		hold = (hp_cfg == 10'd0) ? 10'd1 : hp_cfg;
		done = 1'b0;
		if (eng_phase == PH_IDLE && t.kind && t.command <= CMD_READ_NACK) begin
			eng_cmd = cmd_t'(t.command);
			eng_bits = '0;
			if (eng_cmd == CMD_WRITE) begin
				eng_shift = t.write_data;
				drv_scl = 1'b0;
			end else if (eng_cmd == CMD_READ_ACK || eng_cmd == CMD_READ_NACK) begin
				eng_shift = '0;
				drv_sda = 1'b1;
				drv_scl = 1'b0;
			end
			enter_phase(0);
		end
		// the drive reported is the one in effect during this tick
		shown_scl = drv_scl;
		shown_sda = drv_sda;
		if (eng_phase != PH_IDLE) begin
			eng_count = eng_count + 10'd1;
			if (eng_count >= hold) begin
				next = finish_phase(int'(eng_phase) - 1, t.sda_in);
				if (next < 0) begin
					eng_phase = PH_IDLE;
					eng_count = '0;
					done = 1'b1;
				end else begin
					enter_phase(next);
				end
			end
		end
		return '{shown_scl, shown_sda, eng_phase != PH_IDLE, done, eng_read, eng_nack,
			eng_status};
	endfunction

	// sda level a well-behaved bus would show on this tick; mostly sane, sometimes not
	function automatic logic slave_level(input logic k, input logic [2:0] c);
		cmd_t cmd_now;
		int   s;
		if (eng_phase == PH_IDLE) begin
			if (!(k && c <= CMD_READ_NACK)) return 1'($urandom_range(1));
			cmd_now = cmd_t'(c);
			s = 0;
		end else begin
			cmd_now = eng_cmd;
			s = int'(eng_phase) - 1;
		end
		case (cmd_now)
		CMD_START: begin
			// free bus after release, line follows the master once pulled low
			if (s == 1) return $urandom_range(99) < 92;
			if (s == 3) return $urandom_range(99) >= 92;
		end
		CMD_WRITE: begin
			// slave acks most bytes
			if (s == 3) return $urandom_range(99) >= 80;
		end
		default: ;
		endcase
		return 1'($urandom_range(1));
	endfunction

	function automatic logic [7:0] random_byte();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return 8'h00;
		if (pick == 1) return 8'hFF;
		return 8'($urandom);
	endfunction

	// offer one tick and wait for its transaction, then queue its predicted result
	task automatic send_tick(input tick_t t);
		while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= t.kind;
		command    <= t.command;
		write_data <= t.write_data;
		sda_in     <= t.sda_in;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		line_results.push_back(advance_bus_engine(t));
		ticks_sent++;
	endtask

	// plain ticks until the primitive ends; a few carry commands that must be dropped
	task automatic tick_until_idle(input fill_e mode);
		tick_t t;
		while (eng_phase != PH_IDLE) begin
			t.kind = $urandom_range(99) < 5;
			t.command = 3'($urandom_range(7));
			t.write_data = 8'($urandom);
			case (mode)
			FILL_LOW: t.sda_in = 1'b0;
			FILL_HIGH: t.sda_in = 1'b1;
			default: t.sda_in = slave_level(t.kind, t.command);
			endcase
			send_tick(t);
		end
	endtask

	task automatic run_primitive(input logic [2:0] c, input logic [7:0] wd);
		tick_t t;
		int    n;
		// sometimes a few idle ticks first, now and then with a bad command code
		n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) begin
			t.kind = $urandom_range(9) == 0;
			t.command = t.kind ? 3'($urandom_range(UNUSED_CMD_A, UNUSED_CMD_C))
				: 3'($urandom_range(7));
			t.write_data = 8'($urandom);
			t.sda_in = 1'($urandom_range(1));
			send_tick(t);
		end
		t.kind = 1'b1;
		t.command = c;
		t.write_data = wd;
		t.sda_in = slave_level(1'b1, c);
		send_tick(t);
		tick_until_idle(FILL_SLAVE);
	endtask

	// start, address, one to three data bytes, stop; a failed start goes straight to stop
	task automatic run_transfer();
		int n;
		run_primitive(CMD_START, random_byte());
		if (eng_status == ST_READY) begin
			run_primitive(CMD_WRITE, random_byte());
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(1))
					run_primitive(CMD_WRITE, random_byte());
				else
					run_primitive((i == n - 1) ? CMD_READ_NACK : CMD_READ_ACK, random_byte());
			end
		end
		run_primitive(CMD_STOP, random_byte());
	endtask

	// hold input until every result is back, then let the pipeline settle
	task automatic drain_results();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (line_results.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_half_period(input logic [9:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		hp_cfg = value;
	endtask

	// result side stalls at random while gaps are on
	always @(posedge clk) begin
		out_stall <= gaps_on && ($urandom_range(99) < IDLE_PERCENT);
	end

	// every result transaction is matched against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_result = '{scl_out, sda_out, busy_res, done_res, read_data, nack_seen,
				status_t'(status)};
			if (line_results.size() == 0) begin
				if (fail_count < 10)
					$display("%0t: result transaction with nothing expected", $realtime);
				fail_count++;
			end else begin
				want_result = line_results.pop_front();
				if (got_result !== want_result) begin
					if (fail_count < 10)
						$display({"%0t: mismatch scl/sda/busy/done/rd/nack/status ",
							"expected %b %b %b %b %h %b %0d got %b %b %b %b %h %b %0d"},
							$realtime, want_result.scl_out, want_result.sda_out,
							want_result.busy_res, want_result.done_res,
							want_result.read_data, want_result.nack_seen,
							want_result.status, got_result.scl_out, got_result.sda_out,
							got_result.busy_res, got_result.done_res,
							got_result.read_data, got_result.nack_seen,
							got_result.status);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		plan_row_t row;
		int        phase_start;
		reset_bus_engine();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on = 1'b1;

		// directed rows run at the reset half period
		for (int i = 0; i < $size(DIRECTED_PLAN); i++) begin
			row = DIRECTED_PLAN[i];
			send_tick('{row.kind, row.command, row.write_data, row.sda_in});
			if (row.fill != FILL_NONE) tick_until_idle(row.fill);
			// no time has passed since the last push, so its result is still queued
			if (row.typed) line_results[line_results.size() - 1] = row.want;
		end
		drain_results();

		// random traffic, one half period per phase, engine idle at each change
		for (int p = 0; p < $size(HALF_PERIOD_PLAN); p++) begin
			write_half_period(HALF_PERIOD_PLAN[p]);
			gaps_on = (p != QUIET_PHASE);
			phase_start = ticks_sent;
			if (HALF_PERIOD_PLAN[p] >= SLOW_HALF_PERIOD) begin
				run_primitive(CMD_START, random_byte());
			end else begin
				while (ticks_sent - phase_start < PHASE_TICKS) begin
					if ($urandom_range(99) < 80)
						run_transfer();
					else
						run_primitive(3'($urandom_range(7)), random_byte());
				end
			end
			drain_results();
		end

		fail_count += line_results.size();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== i2c_master_byte_engine.f =====
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_step.sv
rtl/i2c_master_byte_engine.sv
test/tb_top.sv
